>>> sv/lfu_pkg.sv
// ============================================================================
// lfu_pkg: shared types and constants for the LFU bench slot replacement block
// Holds the register map, reset values, stream widths and the slot decision
// struct passed from the slot picker to the top level.
// ============================================================================
package lfu_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // Configuration register width and reset values (hundredths).
    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] PART_VALUE_RST = 8'd10;
    localparam logic [CFG_W-1:0] FETCH_COST_RST = 8'd10;
    localparam logic [CFG_W-1:0] SWAP_COST_RST  = 8'd15;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_PART_VALUE = 2'd0,
        REG_FETCH_COST = 2'd1,
        REG_SWAP_COST  = 2'd2
    } lfu_reg_t;

    // Divide by ten: floor(n * 6554 / 65536) is exact for every 11-bit n.
    localparam int DIV_PROD_W = 24;
    localparam logic [DIV_PROD_W-1:0] DIV10_MUL = 24'd6554;
    localparam int DIV10_SHIFT = 16;
    localparam int RAW_BIN_W = 8;

    // Slot index field wide enough for the largest bench.
    localparam int SLOT_FIELD_W = 4;

    // Decision for one item made against the bench state.
    typedef struct packed {
        logic                    hit;
        logic                    fill;
        logic                    evict;
        logic [SLOT_FIELD_W-1:0] slot;
    } lfu_pick_t;

endpackage

>>> sv/lfu_bench_slot_replacement.sv
// ============================================================================
// lfu_bench_slot_replacement: LFU bench slot replacement
// Maps each part number to a bin, keeps a small fully associative bench of
// bins with per-bin use counts, and reports hit, slot, eviction and a
// running net revenue for every item.
// ============================================================================
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-----------------------------------
//  s_*      | in        | s_tvalid/s_tready | part_number
//  m_*      | out       | m_tvalid/m_tready | bin_id, hit, slot_used, evicted,
//           |           |                   | evicted_bin, net_revenue,
//           |           |                   | item_total
//  APB      | in/out    | psel/penable      | part_value, fetch_cost, swap_cost
//
//  One item per cycle is sustained unless the output stalls; a result passes the
//  bench stage and output registers onto m_tdata (count read on acceptance, bench
//  updated as the item leaves). After reset the whole count memory is cleared one
//  entry a cycle, with s_tready low; configuration writes work as ever.
//  A stalled output holds its result and the bench stage behind it; input is
//  still taken while the bench stage is empty or moving into the output.
//
module lfu_bench_slot_replacement
    import lfu_pkg::*;
#(
    parameter int NUM_SLOTS  = 5,
    parameter int NUM_BINS   = 128,
    parameter int COUNT_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [10:0] part_number, [15:11] zero
    input  logic [IN_TDATA_W-1:0]   s_tdata,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [6:0] bin_id, [7] hit, [10:8] slot_used, [11] evicted,
    // [18:12] evicted_bin, [50:19] net_revenue, [82:51] item_total, [87:83] zero
    output logic [OUT_TDATA_W-1:0]  m_tdata,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration registers.
    logic [CFG_W-1:0] part_value_reg;
    logic [CFG_W-1:0] fetch_cost_reg;
    logic [CFG_W-1:0] swap_cost_reg;
    logic             cfg_wr;
    lfu_reg_t         cfg_idx;

    // Count memory and its clearing pass.
    logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  clr_busy_reg;
    logic [BIN_W-1:0]      clr_addr_reg;
    logic                  mem_we;
    logic [BIN_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // Input side.
    logic                  s_fire;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [RAW_BIN_W-1:0]  raw_bin;
    logic [BIN_W-1:0]      in_bin;

    // Bench stage.
    logic                  s1_valid_reg;
    logic [BIN_W-1:0]      s1_bin_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_cnt_reg;
    logic                  s1_fire;

    // Bench state.
    logic [NUM_SLOTS-1:0]                 slot_valid_reg;
    logic [NUM_SLOTS-1:0][BIN_W-1:0]      bench_bins_reg;
    logic [NUM_SLOTS-1:0][COUNT_BITS-1:0] slot_cnt_reg;
    logic signed [31:0]                   net_total_reg;
    logic [31:0]                          item_cnt_reg;

    // Bench stage results.
    lfu_pick_t             pick;
    logic [SLOT_W-1:0]     slot_idx;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [CFG_W-1:0]      cost;
    logic signed [33:0]    net_sum;
    logic signed [31:0]    net_next;
    logic [31:0]           item_next;
    logic [BIN_W-1:0]      ev_bin;
    logic [31:0]           bin_wide;
    logic [31:0]           ev_wide;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // ------------------------------------------------------------------
    // APB configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = lfu_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_value_reg <= PART_VALUE_RST;
            fetch_cost_reg <= FETCH_COST_RST;
            swap_cost_reg  <= SWAP_COST_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PART_VALUE: part_value_reg <= pwdata[CFG_W-1:0];
                REG_FETCH_COST: fetch_cost_reg <= pwdata[CFG_W-1:0];
                REG_SWAP_COST:  swap_cost_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PART_VALUE: prdata = 32'(part_value_reg);
            REG_FETCH_COST: prdata = 32'(fetch_cost_reg);
            REG_SWAP_COST:  prdata = 32'(swap_cost_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake control.
    // ------------------------------------------------------------------
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_fire && (s1_bin_reg == in_bin);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bin from part number: divide by ten, clamp to the table.
    // ------------------------------------------------------------------
    assign div_prod = DIV_PROD_W'(s_tdata[10:0]) * DIV10_MUL;
    assign raw_bin  = div_prod[DIV10_SHIFT +: RAW_BIN_W];
    assign in_bin   = (32'(raw_bin) >= NUM_BINS) ? LAST_BIN : BIN_W'(raw_bin);

    // Bench stage payload; the forwarded count covers a write to the same bin
    // at the edge where this item's read took place.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_bin_reg  <= in_bin;
            fwd_cnt_reg <= new_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Count memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_BIN)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign mem_we    = clr_busy_reg || s1_fire;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_bin_reg;
    assign mem_wdata = clr_busy_reg ? '0 : new_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire)
        begin
            rdata_reg <= cnt_mem[in_bin];
        end
    end

    // ------------------------------------------------------------------
    // Bench decision and result.
    // ------------------------------------------------------------------
    lfu_slot_pick #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BIN_W      (BIN_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_pick (
        .bin         (s1_bin_reg),
        .slot_valid  (slot_valid_reg),
        .slot_bins   (bench_bins_reg),
        .slot_counts (slot_cnt_reg),
        .pick        (pick)
    );

    assign slot_idx = pick.slot[SLOT_W-1:0];
    assign cur_cnt  = fwd_hit_reg ? fwd_cnt_reg : rdata_reg;
    assign new_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

    // Revenue: part value in, fetch or swap cost out, clamped to 32 bits.
    always_comb
    begin
        if (pick.hit)
        begin
            cost = '0;
        end
        else if (pick.fill)
        begin
            cost = fetch_cost_reg;
        end
        else
        begin
            cost = swap_cost_reg;
        end
        net_sum = 34'(net_total_reg) + $signed({26'd0, part_value_reg})
                  - $signed({26'd0, cost});
        if (net_sum > 34'sd2147483647)
        begin
            net_next = 32'sh7fffffff;
        end
        else if (net_sum < -34'sd2147483648)
        begin
            net_next = 32'sh80000000;
        end
        else
        begin
            net_next = net_sum[31:0];
        end
        item_next = (item_cnt_reg == '1) ? item_cnt_reg : item_cnt_reg + 1'b1;
    end

    assign ev_bin   = pick.evict ? bench_bins_reg[slot_idx] : '0;
    assign bin_wide = 32'(s1_bin_reg);
    assign ev_wide  = 32'(ev_bin);
    assign out_data_next = {5'd0, item_next, net_next, ev_wide[6:0], pick.evict,
                            pick.slot[2:0], pick.hit, bin_wide[6:0]};

    // Control state of the bench.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            net_total_reg  <= '0;
            item_cnt_reg   <= '0;
        end
        else if (s1_fire)
        begin
            slot_valid_reg[slot_idx] <= 1'b1;
            net_total_reg            <= net_next;
            item_cnt_reg             <= item_next;
        end
    end

    // Bench payload and the output register.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            bench_bins_reg[slot_idx] <= s1_bin_reg;
            slot_cnt_reg[slot_idx]   <= new_cnt;
            out_data_reg             <= out_data_next;
        end
    end

endmodule

>>> sv/lfu_slot_pick.sv
// ============================================================================
// lfu_slot_pick: bench slot lookup and victim choice
// Compares the bin against every occupied slot, finds the lowest empty slot,
// and finds the slot with the smallest use count (lowest index wins).
// ============================================================================
module lfu_slot_pick
    import lfu_pkg::*;
#(
    parameter int NUM_SLOTS  = 5,
    parameter int BIN_W      = 7,
    parameter int COUNT_BITS = 16
)
(
    input  logic [BIN_W-1:0]                      bin,
    input  logic [NUM_SLOTS-1:0]                  slot_valid,
    input  logic [NUM_SLOTS-1:0][BIN_W-1:0]       slot_bins,
    input  logic [NUM_SLOTS-1:0][COUNT_BITS-1:0]  slot_counts,
    output lfu_pick_t                             pick
);

    logic                    hit_found;
    logic [SLOT_FIELD_W-1:0] hit_idx;
    logic                    empty_found;
    logic [SLOT_FIELD_W-1:0] empty_idx;
    logic [COUNT_BITS-1:0]   min_cnt;
    logic [SLOT_FIELD_W-1:0] min_idx;

    // Match and empty search; scanning downward leaves the lowest index.
    always_comb
    begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid[i] && (slot_bins[i] == bin))
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_FIELD_W'(i);
            end
            if (!slot_valid[i])
            begin
                empty_found = 1'b1;
                empty_idx   = SLOT_FIELD_W'(i);
            end
        end
    end

    // Least used slot; a strict compare keeps the lowest index on ties.
    always_comb
    begin
        min_cnt = slot_counts[0];
        min_idx = '0;
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            if (slot_counts[i] < min_cnt)
            begin
                min_cnt = slot_counts[i];
                min_idx = SLOT_FIELD_W'(i);
            end
        end
    end

    // Hit beats fill, fill beats eviction.
    always_comb
    begin
        pick.hit   = hit_found;
        pick.fill  = !hit_found && empty_found;
        pick.evict = !hit_found && !empty_found;
        if (hit_found)
        begin
            pick.slot = hit_idx;
        end
        else if (empty_found)
        begin
            pick.slot = empty_idx;
        end
        else
        begin
            pick.slot = min_idx;
        end
    end

endmodule

>>> sv/lfu_port_chk.sv
// ============================================================================
// lfu_port_chk: port checker for the LFU bench slot replacement block
// Watches the result stream and checks holding under stall and the
// consistency of the hit, slot and eviction fields.
// ============================================================================
module lfu_port_chk
    import lfu_pkg::*;
#(
    parameter int NUM_SLOTS = 5
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[7] && m_tdata[11]))
        else $error("hit and eviction reported together");

    // Without an eviction the evicted bin reads zero.
    a_evbin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[11] |-> (m_tdata[18:12] == 7'd0))
        else $error("evicted bin set without eviction");

    // The reported slot lies on the bench.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((NUM_SLOTS >= 8) || (int'(m_tdata[10:8]) < NUM_SLOTS)))
        else $error("slot beyond the bench");

endmodule

bind lfu_bench_slot_replacement lfu_port_chk #(
    .NUM_SLOTS (NUM_SLOTS)
) u_port_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the LFU bench slot replacement block
// Streams part numbers into the block and keeps its own model of the bench
// slots, per-bin use counts and running revenue. Every result item is
// compared field by field with the model. Register reads are checked the
// same way. The run covers the reset values, directed corner items and
// random traffic under several idle patterns and cost settings.
// ============================================================================
module tb
    import lfu_pkg::*;
;

    localparam int BENCH_SLOTS = 5;
    localparam int BIN_COUNT = 128;
    localparam int PARTS_PER_BIN = 10;
    localparam int PART_MAX = 2047;
    localparam logic [15:0] USE_COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] PARTS_SEEN_MAX = 32'hFFFF_FFFF;
    localparam longint NET_MAX = 64'sd2147483647;
    localparam longint NET_MIN = -64'sd2147483648;
    // Index 3 is past the end of the register map.
    localparam logic [3:0] SPARE_REG_ADDR = 4'hC;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 317;
    localparam int HOT_BIN_PCT = 65;

    // One result item, laid out as on m_tdata from the highest bit down.
    typedef struct packed {
        logic [31:0] total;
        logic [31:0] net;
        logic [6:0]  ev_bin;
        logic        evicted;
        logic [2:0]  slot;
        logic        hit;
        logic [6:0]  bin;
    } bench_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // [10:0] part_number, [15:11] zero
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // [6:0] bin_id, [7] hit, [10:8] slot_used, [11] evicted,
    // [18:12] evicted_bin, [50:19] net_revenue, [82:51] item_total, [87:83] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // Model of the block: cost registers, bench slots and running totals.
    logic [7:0]    cfg_part_value = PART_VALUE_RST;
    logic [7:0]    cfg_fetch_cost = FETCH_COST_RST;
    logic [7:0]    cfg_swap_cost = SWAP_COST_RST;
    logic [6:0]    bench_bin [BENCH_SLOTS] = '{default: '0};
    logic          bench_valid [BENCH_SLOTS] = '{default: 1'b0};
    logic [15:0]   bench_count [BENCH_SLOTS] = '{default: '0};
    logic [15:0]   bin_use_count [BIN_COUNT] = '{default: '0};
    longint        revenue_total = 0;
    logic [31:0]   parts_seen = '0;
    bench_result_t pending_results [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;

    lfu_bench_slot_replacement dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver stalls at random at the current rate.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic logic [3:0] reg_addr(input lfu_reg_t r);
        return {r, 2'b00};
    endfunction

    // Works out the result of one accepted part number and updates the model.
    task automatic predict_bench_result(input logic [10:0] part);
        int            bin;
        int            slot;
        bit            found;
        bit            empty;
        logic [15:0]   best;
        longint        revenue;
        bench_result_t res;

        bin = part / PARTS_PER_BIN;
        if (bin >= BIN_COUNT)
        begin
            bin = BIN_COUNT - 1;
        end
        res = '0;
        res.bin = bin[6:0];
        revenue = revenue_total + longint'(cfg_part_value);
        found = 1'b0;
        slot = 0;
        for (int i = 0; i < BENCH_SLOTS; i++)
        begin
            if (!found && bench_valid[i] && bench_bin[i] == bin)
            begin
                found = 1'b1;
                slot = i;
            end
        end

        if (found)
        begin
            res.hit = 1'b1;
        end
        else
        begin
            // A miss takes the lowest empty slot, else the least used one.
            empty = 1'b0;
            for (int i = 0; i < BENCH_SLOTS; i++)
            begin
                if (!empty && !bench_valid[i])
                begin
                    empty = 1'b1;
                    slot = i;
                end
            end
            if (empty)
            begin
                revenue -= longint'(cfg_fetch_cost);
            end
            else
            begin
                best = bench_count[0];
                slot = 0;
                for (int i = 1; i < BENCH_SLOTS; i++)
                begin
                    if (bench_count[i] < best)
                    begin
                        best = bench_count[i];
                        slot = i;
                    end
                end
                res.evicted = 1'b1;
                res.ev_bin = bench_bin[slot];
                revenue -= longint'(cfg_swap_cost);
            end
            bench_bin[slot] = bin[6:0];
            bench_valid[slot] = 1'b1;
        end

        // Use counts survive eviction and stick at their maximum.
        if (bin_use_count[bin] != USE_COUNT_MAX)
        begin
            bin_use_count[bin]++;
        end
        bench_count[slot] = bin_use_count[bin];

        if (revenue > NET_MAX)
        begin
            revenue = NET_MAX;
        end
        if (revenue < NET_MIN)
        begin
            revenue = NET_MIN;
        end
        revenue_total = revenue;
        if (parts_seen != PARTS_SEEN_MAX)
        begin
            parts_seen++;
        end

        res.slot = slot[2:0];
        res.net = revenue[31:0];
        res.total = parts_seen;
        pending_results.push_back(res);
    endtask

    // Compares each result item with the oldest pending prediction.
    always @(posedge clk)
    begin : check_results
        bench_result_t got;
        bench_result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[82:0];
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result item with none pending, bin_id %0d",
                                          got.bin));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("bin_id", got.bin, want.bin);
                check_field("hit", got.hit, want.hit);
                check_field("slot_used", got.slot, want.slot);
                check_field("evicted", got.evicted, want.evicted);
                check_field("evicted_bin", got.ev_bin, want.ev_bin);
                check_field("net_revenue", $signed(got.net), $signed(want.net));
                check_field("item_total", got.total, want.total);
            end
        end
    end

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic write, input logic [3:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input lfu_reg_t r);
        logic [31:0] rdata;
        logic [7:0]  want;

        apb_access(1'b0, reg_addr(r), '0, rdata);
        case (r)
            REG_PART_VALUE: want = cfg_part_value;
            REG_FETCH_COST: want = cfg_fetch_cost;
            default:        want = cfg_swap_cost;
        endcase
        check_field($sformatf("register %s", r.name()), rdata[7:0], want);
    endtask

    task automatic check_all_registers;
        check_register(REG_PART_VALUE);
        check_register(REG_FETCH_COST);
        check_register(REG_SWAP_COST);
    endtask

    // Writes a register and reads it back; the spare address changes nothing.
    task automatic cfg_write(input logic [3:0] addr, input logic [7:0] value);
        logic [31:0] rdata;

        apb_access(1'b1, addr, {24'd0, value}, rdata);
        if (addr != SPARE_REG_ADDR)
        begin
            case (addr[3:2])
                REG_PART_VALUE: cfg_part_value = value;
                REG_FETCH_COST: cfg_fetch_cost = value;
                REG_SWAP_COST:  cfg_swap_cost = value;
                default: ;
            endcase
            check_register(lfu_reg_t'(addr[3:2]));
        end
    endtask

    task automatic set_costs(input logic [7:0] value, input logic [7:0] fetch,
                             input logic [7:0] swap);
        cfg_write(reg_addr(REG_PART_VALUE), value);
        cfg_write(reg_addr(REG_FETCH_COST), fetch);
        cfg_write(reg_addr(REG_SWAP_COST), swap);
    endtask

    // Sends one part number item, with random idle cycles ahead of it.
    task automatic send_part(input logic [10:0] part);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, part};
        do @(posedge clk); while (!s_tready);
        predict_bench_result(part);
    endtask

    // Stops sending and waits until every pending result item has arrived.
    task automatic wait_idle;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reset values, every register bit both ways and the unmapped index.
    task automatic test_register_access;
        check_all_registers();
        set_costs(8'hFF, 8'h00, 8'h00);
        set_costs(8'h00, 8'hFF, 8'hFF);
        cfg_write(SPARE_REG_ADDR, 8'h5A);
        check_all_registers();
    endtask

    // Fills, hits, clamped bins, then evictions with ties and revisited bins.
    task automatic test_directed_items;
        logic [10:0] fill_parts [8] = '{11'd0, 11'd9, 11'd10, 11'd1279, 11'd1280,
                                        11'd2047, 11'd20, 11'd30};
        logic [10:0] evict_parts [7] = '{11'd50, 11'd10, 11'd1023, 11'd1024, 11'd0,
                                         11'd9, 11'd2047};

        send_idle_pct = 13;
        recv_idle_pct = 46;
        foreach (fill_parts[i])
        begin
            send_part(fill_parts[i]);
        end
        wait_idle();
        set_costs(8'hFF, 8'h00, 8'hFF);
        foreach (evict_parts[i])
        begin
            send_part(evict_parts[i]);
        end
        wait_idle();
    endtask

    // Mostly a small set of hot bins so that hits and LFU choices matter,
    // mixed with part numbers drawn from the whole field.
    task automatic run_traffic_phase(input int send_pct, input int recv_pct,
                                     input logic [7:0] value, input logic [7:0] fetch,
                                     input logic [7:0] swap);
        logic [6:0]  hot_bins [8];
        logic [10:0] part;

        set_costs(value, fetch, swap);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (hot_bins[i])
        begin
            hot_bins[i] = 7'($urandom_range(BIN_COUNT - 1));
        end
        repeat (PHASE_ITEMS)
        begin
            if ($urandom_range(99) < HOT_BIN_PCT)
            begin
                part = 11'(hot_bins[3'($urandom_range(7))] * PARTS_PER_BIN
                           + $urandom_range(PARTS_PER_BIN - 1));
            end
            else
            begin
                part = 11'($urandom_range(PART_MAX));
            end
            send_part(part);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic;
        run_traffic_phase(13, 46, 8'hFF, 8'h00, 8'h00);
        run_traffic_phase(46, 13, 8'h00, 8'hFF, 8'hFF);
        run_traffic_phase(0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_items();
        test_random_traffic();

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
